/* rtl/core/dq_pkg.sv */
`default_nettype none

package dq_pkg;

    // default sizes
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths on the ports
    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_PUSH_FULL = 2'd2
    } status_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic    en;
        action_t act;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/dq_cell.sv */
`default_nettype none

module dq_cell #(
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dq_pkg::cell_cmd_t     cmd,
    input  wire logic [DATA_WIDTH-1:0] push_data,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic                  left_valid,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic                  right_valid,
    output logic      [DATA_WIDTH-1:0] data_out,
    output logic                       valid_out,
    output logic                       back_out
);

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic                  valid_reg, valid_next;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (cmd.en) begin
            unique case (cmd.act)
                dq_pkg::ACT_PUSH_FRONT: begin
                    // shift toward the back
                    data_next  = left_data;
                    valid_next = left_valid;
                end
                dq_pkg::ACT_PUSH_BACK: begin
                    // first empty cell takes the word
                    if (!valid_reg && left_valid) begin
                        data_next  = push_data;
                        valid_next = 1'b1;
                    end
                end
                dq_pkg::ACT_POP_FRONT: begin
                    // shift toward the front
                    data_next  = right_data;
                    valid_next = right_valid;
                end
                dq_pkg::ACT_POP_BACK: begin
                    if (valid_reg && !right_valid) begin
                        valid_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;
    assign back_out  = valid_reg && !right_valid;

endmodule

`default_nettype wire

/* rtl/core/dq_readout.sv */
`default_nettype none

module dq_readout #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic [DATA_WIDTH-1:0]      cell_data [DEPTH],
    input  wire logic [DEPTH-1:0]           cell_back,
    input  wire logic                       front_valid,
    output logic      [dq_pkg::FIELD_W-1:0] front_value,
    output logic      [dq_pkg::FIELD_W-1:0] back_value
);

    logic [DATA_WIDTH-1:0] front_full;
    logic [DATA_WIDTH-1:0] back_full;

    // exactly one cell flags itself as the back, none when empty
    always_comb begin
        back_full = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_full = back_full | (cell_data[i] & {DATA_WIDTH{cell_back[i]}});
        end
    end

    assign front_full = cell_data[0] & {DATA_WIDTH{front_valid}};

    generate
        if (DATA_WIDTH >= dq_pkg::FIELD_W) begin : g_trunc
            assign front_value = front_full[dq_pkg::FIELD_W-1:0];
            assign back_value  = back_full[dq_pkg::FIELD_W-1:0];
        end else begin : g_ext
            assign front_value = {{(dq_pkg::FIELD_W-DATA_WIDTH){1'b0}}, front_full};
            assign back_value  = {{(dq_pkg::FIELD_W-DATA_WIDTH){1'b0}}, back_full};
        end
    endgenerate

endmodule

`default_nettype wire

/* rtl/core/double_ended_queue.sv */
// one word in flight: the next word is accepted once the last result is in the output
//   register and the slot is free; the cell chain updates in the accept cycle and the
//   front/back readout over the cells is registered in the following cycle
// reset: synchronous active-low aresetn empties the deque (cell valid bits, count) and
//   clears the handshake state; stored data is not cleared and needs no clearing pass
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // push_value[31:0]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // front_value[31:0], back_value[63:32],
                                        // element_count[68:64], zero pad[71:69]
    output logic      [1:0]  m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // input decode
    logic                  s_accept;
    dq_pkg::action_t       action;
    logic [DATA_WIDTH-1:0] push_data;

    assign s_accept = s_tvalid && s_tready;
    assign action   = dq_pkg::action_t'(s_tuser);

    generate
        if (DATA_WIDTH > dq_pkg::FIELD_W) begin : g_push_ext
            assign push_data = {{(DATA_WIDTH-dq_pkg::FIELD_W){1'b0}}, s_tdata};
        end else begin : g_push_trunc
            assign push_data = s_tdata[DATA_WIDTH-1:0];
        end
    endgenerate

    // cell chain
    logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
    logic [DEPTH-1:0]      cell_valid;
    logic [DEPTH-1:0]      cell_back;
    dq_pkg::cell_cmd_t     cmd;

    logic full;
    logic empty;

    assign full  = cell_valid[DEPTH-1];
    assign empty = !cell_valid[0];

    // control state
    logic                  pend_reg, pend_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    dq_pkg::status_t       status_reg, status_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [dq_pkg::FIELD_W-1:0] front_reg, back_reg;
    logic [dq_pkg::COUNT_W-1:0] count_out_reg;
    dq_pkg::status_t       m_status_reg;

    // one word in flight; taken only when the output slot will be free
    assign s_tready = !pend_reg && (!m_valid_reg || m_tready);

    // command and status of the accepted word
    always_comb begin
        cmd.en      = 1'b0;
        cmd.act     = action;
        status_next = status_reg;
        count_next  = count_reg;
        if (s_accept) begin
            status_next = dq_pkg::STAT_OK;
            unique case (action)
                dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
                    if (full) begin
                        status_next = dq_pkg::STAT_PUSH_FULL;
                    end else begin
                        cmd.en     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
                    if (empty) begin
                        status_next = dq_pkg::STAT_POP_EMPTY;
                    end else begin
                        cmd.en     = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_data;
            logic                  left_valid;
            logic [DATA_WIDTH-1:0] right_data;
            logic                  right_valid;

            // front cell sees the incoming word as its left neighbor
            if (gi == 0) begin : g_first
                assign left_data  = push_data;
                assign left_valid = 1'b1;
            end else begin : g_mid_l
                assign left_data  = cell_data[gi-1];
                assign left_valid = cell_valid[gi-1];
            end

            // last cell sees an empty right neighbor
            if (gi == DEPTH - 1) begin : g_last
                assign right_data  = '0;
                assign right_valid = 1'b0;
            end else begin : g_mid_r
                assign right_data  = cell_data[gi+1];
                assign right_valid = cell_valid[gi+1];
            end

            dq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .push_data   (push_data),
                .left_data   (left_data),
                .left_valid  (left_valid),
                .right_data  (right_data),
                .right_valid (right_valid),
                .data_out    (cell_data[gi]),
                .valid_out   (cell_valid[gi]),
                .back_out    (cell_back[gi])
            );
        end
    endgenerate

    // front/back readout from the updated chain
    logic [dq_pkg::FIELD_W-1:0] front_value;
    logic [dq_pkg::FIELD_W-1:0] back_value;
    logic [dq_pkg::COUNT_W-1:0] count_field;

    dq_readout #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_readout (
        .cell_data   (cell_data),
        .cell_back   (cell_back),
        .front_valid (cell_valid[0]),
        .front_value (front_value),
        .back_value  (back_value)
    );

    generate
        if (CNT_W >= dq_pkg::COUNT_W) begin : g_cnt_trunc
            assign count_field = count_reg[dq_pkg::COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign count_field = {{(dq_pkg::COUNT_W-CNT_W){1'b0}}, count_reg};
        end
    endgenerate

    // handshake control
    always_comb begin
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (pend_reg) begin
            // cells have settled; load the result
            pend_next    = 1'b0;
            m_valid_next = 1'b1;
        end
        if (s_accept) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            status_reg  <= dq_pkg::STAT_OK;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            status_reg  <= status_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            front_reg     <= front_value;
            back_reg      <= back_value;
            count_out_reg <= count_field;
            m_status_reg  <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, count_out_reg, back_reg, front_reg};
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire
